// ===== rtl/core/tgcr_pkg.sv =====
// Shared types and constants for the text glyph column renderer.
// Holds the 5x7 font table, glyph code limits and the divide unit request/response structs.
// No dependencies.
package tgcr_pkg;

  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned FONT_ROWS  = 96;
  localparam int unsigned MAX_DIGITS = 10;

  localparam logic [7:0] GLYPH_FIRST  = 8'h20;
  localparam logic [7:0] GLYPH_LAST   = 8'h7F;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] BLANK_COLUMN = 8'h00;

  // Last column of a cell is the blank spacer
  localparam logic [2:0] SPACER_COL = 3'd5;

  // ceil(2^35 / 10): value * RECIP_10 >> 35 is value / 10 for any 32-bit value
  localparam logic [31:0] RECIP_10   = 32'hCCCCCCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // One glyph per entry, column 0 in the top byte
  localparam logic [39:0] FONT [FONT_ROWS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [3:0]  rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/tgcr_in_if.sv =====
// Input channel of the glyph renderer: valid/ready plus one item word.
// No dependencies.
interface tgcr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  char_code;
  logic [31:0] number;

  modport source (output valid, output func, output char_code, output number, input ready);
  modport sink   (input valid, input func, input char_code, input number, output ready);
endinterface

// ===== rtl/core/tgcr_out_if.sv =====
// Output channel of the glyph renderer: valid/ready plus one column word.
// No dependencies.
interface tgcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_byte;
  logic       last;

  modport source (output valid, output column_byte, output last, input ready);
  modport sink   (input valid, input column_byte, input last, output ready);
endinterface

// ===== rtl/core/text_glyph_column_renderer_core.sv =====
// Top level of the text glyph column renderer: sequencer, digit store and output register.
// Depends on tgcr_pkg, tgcr_in_if, tgcr_out_if, tgcr_div10 and tgcr_glyph.
//
// Usage:
//   item   : input words. func = 0 draws char_code, func = 1 draws number in decimal.
//   column : output words, one 8-bit pixel column each (bit 0 top row), last set on
//            the final column of an item.
//   A character gives 6 words: five font columns and a blank spacer. A number gives
//   6 words per decimal digit, 6 to 60 words, most significant digit first.
//   item.ready is high only while the block is idle; one item is worked at a time.
//   A number is split into digits by a divide-by-ten unit (reciprocal multiply,
//   then remainder correction) under the sequencer, one digit per division.
//   Columns then go out one per cycle while the output register is free or taken.
//   The final word of an item may still wait in the output register while the next
//   item is taken. When the receiver stalls, the output register holds its word
//   and the sequencer waits. Synchronous reset empties the output register and
//   returns the sequencer to idle; no memory needs clearing.
module text_glyph_column_renderer_core
  import tgcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tgcr_in_if.sink     item,
  tgcr_out_if.source  column
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_ISSUE,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t      state;
  logic        char_mode;
  logic [7:0]  char_reg;
  logic [31:0] value;
  logic [3:0]  digits [MAX_DIGITS];
  logic [3:0]  count;
  logic [3:0]  idx;
  logic [2:0]  col;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [7:0]  cell_code;
  logic [7:0]  glyph_byte;

  assign item.ready         = (state == S_IDLE);
  assign column.valid       = out_valid;
  assign column.column_byte = out_byte;
  assign column.last        = out_last;

  assign div_req.start = (state == S_DIV_ISSUE);
  assign div_req.value = value;

  // Character to draw for the current cell
  assign cell_code = char_mode ? char_reg : (DIGIT_ZERO + {4'b0000, digits[idx]});

  tgcr_div10 u_div10 (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tgcr_glyph u_glyph (
    .code        (cell_code),
    .col         (col),
    .column_byte (glyph_byte)
  );

  // Sequencer: take an item, split digits, then stream cell columns
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the output word once taken; emit keeps the register full
      if (column.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            char_mode <= ~item.func;
            char_reg  <= item.char_code;
            value     <= item.number;
            count     <= 4'd0;
            idx       <= 4'd0;
            col       <= 3'd0;
            state     <= item.func ? S_DIV_ISSUE : S_EMIT;
          end
        end
        S_DIV_ISSUE: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          // Store the remainder as the next digit, least significant first
          if (div_rsp.done) begin
            digits[count] <= div_rsp.rem;
            count         <= count + 4'd1;
            if (div_rsp.quot == 32'd0) begin
              idx   <= count;
              col   <= 3'd0;
              state <= S_EMIT;
            end else begin
              value <= div_rsp.quot;
              state <= S_DIV_ISSUE;
            end
          end
        end
        S_EMIT: begin
          // Advance one column whenever the output register is free
          if (!out_valid || column.ready) begin
            out_valid <= 1'b1;
            out_byte  <= glyph_byte;
            out_last  <= (col == SPACER_COL) && (idx == 4'd0);
            if (col == SPACER_COL) begin
              col <= 3'd0;
              if (idx == 4'd0) begin
                state <= S_IDLE;
              end else begin
                idx <= idx - 4'd1;
              end
            end else begin
              col <= col + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tgcr_div10.sv =====
// Divide-by-ten unit: reciprocal multiply, then remainder correction.
// Start is registered as busy, and busy as done. Depends on tgcr_pkg.
module tgcr_div10
  import tgcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] prod;
  logic [31:0] held;
  logic        busy;
  logic [28:0] quot_w;
  logic [31:0] quot_x10;
  logic [31:0] rem_w;

  // Take the quotient from the top product bits, then value - 10 * quotient
  assign quot_w   = prod[63:RECIP_SHIFT];
  assign quot_x10 = {quot_w, 3'b000} + {2'b00, quot_w, 1'b0};
  assign rem_w    = held - quot_x10;

  // Stage one: multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= req.start;
    end
    if (req.start) begin
      prod <= 64'(req.value) * 64'(RECIP_10);
      held <= req.value;
    end
  end

  // Stage two: register quotient and remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= busy;
    end
    if (busy) begin
      rsp.quot <= {3'b000, quot_w};
      rsp.rem  <= rem_w[3:0];
    end
  end

endmodule

// ===== rtl/core/tgcr_glyph.sv =====
// Font lookup: maps a character code and a cell column to one column byte.
// Codes outside 0x20..0x7F fall back to the space glyph. Depends on tgcr_pkg.
module tgcr_glyph
  import tgcr_pkg::*;
(
  input  logic [7:0] code,
  input  logic [2:0] col,
  output logic [7:0] column_byte
);

  logic [6:0]  row;
  logic [39:0] glyph;

  // Replace codes outside the font range by a space
  always_comb begin
    if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
      row = 7'd0;
    end else begin
      row = 7'(code - GLYPH_FIRST);
    end
  end

  assign glyph = FONT[row];

  // Pick the column; the spacer column is blank
  always_comb begin
    case (col)
      3'd0:    column_byte = glyph[39:32];
      3'd1:    column_byte = glyph[31:24];
      3'd2:    column_byte = glyph[23:16];
      3'd3:    column_byte = glyph[15:8];
      3'd4:    column_byte = glyph[7:0];
      default: column_byte = BLANK_COLUMN;
    endcase
  end

endmodule

// ===== rtl/core/tgcr_checker.sv =====
// Port-level checks for the glyph renderer and the bind that attaches them.
// Depends on text_glyph_column_renderer_core.
module tgcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // One item at a time: ready drops after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item.ready stayed high after an accepted word");

  // While idle, only the final word of an item may still wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_last)
    else $error("non-final column word pending while idle");

  // The final word is always the blank spacer
  a_last_is_spacer: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == 8'h00)
    else $error("final column word is not blank");

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled column word changed");

endmodule

bind text_glyph_column_renderer_core tgcr_checker u_tgcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (column.valid),
  .out_ready (column.ready),
  .out_byte  (column.column_byte),
  .out_last  (column.last)
);

// ===== dv/tb_text_glyph_column_renderer_core.sv =====
// Testbench for text_glyph_column_renderer_core: sends character and number items,
// predicts the pixel column words of each and checks them in order under random stalls.
// Depends on tgcr_pkg, tgcr_in_if, tgcr_out_if and the renderer RTL.
module tb_text_glyph_column_renderer_core;

  typedef enum logic {
    FUNC_CHAR   = 1'b0,
    FUNC_NUMBER = 1'b1
  } item_func_e;

  typedef struct packed {
    logic [7:0] column_byte;
    logic       last;
  } column_word_t;

  localparam logic [7:0]  CHAR_FIRST     = 8'h20;
  localparam logic [7:0]  CHAR_LAST      = 8'h7F;
  localparam logic [7:0]  CHAR_DIGIT_0   = 8'h30;
  localparam logic [7:0]  SPACER_BYTE    = 8'h00;
  localparam int          FONT_COLS      = 5;
  localparam int          CELL_WIDTH     = 6;
  localparam int unsigned QUIET_LIMIT    = 1000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // 5x7 font, codes 0x20..0x7F, column 0 in the top byte
  localparam logic [39:0] GLYPH_ROM [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  logic clk;
  logic rst;

  tgcr_in_if  item_if ();
  tgcr_out_if col_if ();

  text_glyph_column_renderer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .column (col_if)
  );

  column_word_t pending_columns[$];
  int unsigned  mismatches;
  int unsigned  send_gap_max;
  int unsigned  recv_stall_max;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Queue the six column words of one character cell
  function automatic void render_cell(input logic [7:0] code);
    logic [7:0]   row;
    column_word_t word;
    if (code < CHAR_FIRST || code > CHAR_LAST) begin
      code = CHAR_FIRST;
    end
    row = code - CHAR_FIRST;
    for (int k = 0; k < CELL_WIDTH; k++) begin
      word.column_byte = (k < FONT_COLS) ? GLYPH_ROM[row][39 - 8 * k -: 8] : SPACER_BYTE;
      word.last        = 1'b0;
      pending_columns.push_back(word);
    end
  endfunction

  // Queue every column word of one item and flag its final word
  function automatic void render_item(input item_func_e func, input logic [7:0] code,
                                      input logic [31:0] number);
    logic [3:0]   digits [10];
    logic [31:0]  rest;
    int           count;
    column_word_t tail;
    count = 0;
    rest  = number;
    if (func == FUNC_CHAR) begin
      render_cell(code);
    end else begin
      do begin
        digits[count] = 4'(rest % 10);
        rest          = rest / 10;
        count++;
      end while (rest != 0);
      while (count > 0) begin
        count--;
        render_cell(CHAR_DIGIT_0 + 8'(digits[count]));
      end
    end
    tail      = pending_columns.pop_back();
    tail.last = 1'b1;
    pending_columns.push_back(tail);
  endfunction

  // Send one item word after a random gap; keep valid high when the gap is zero
  task automatic send_item(input item_func_e func, input logic [7:0] code,
                           input logic [31:0] number);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      item_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_if.valid     = 1'b1;
    item_if.func      = func;
    item_if.char_code = code;
    item_if.number    = number;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    render_item(func, code, number);
  endtask

  // Hold the sender until every pending column word has arrived
  task automatic hold_until_drained();
    @(negedge clk);
    item_if.valid = 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
  endtask

  // Pick a random item, mostly printable characters and numbers of every digit count
  task automatic send_random_item();
    item_func_e      func;
    logic [7:0]      code;
    logic [31:0]     number;
    int unsigned     ndigits;
    longint unsigned low_bound;
    longint unsigned high_bound;
    longint unsigned scale;
    func = item_func_e'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
    end else begin
      code = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 3) == 0) begin
      number = $urandom;
    end else begin
      ndigits = $urandom_range(1, 10);
      scale   = 1;
      repeat (ndigits - 1) scale = scale * 10;
      low_bound  = (ndigits == 1) ? 0 : scale;
      high_bound = scale * 10 - 1;
      if (high_bound > 64'hFFFF_FFFF) begin
        high_bound = 64'hFFFF_FFFF;
      end
      number = 32'(low_bound + ({$urandom, $urandom} % (high_bound - low_bound + 1)));
    end
    send_item(func, code, number);
  endtask

  task automatic test_printable_extremes();
    send_gap_max   = 3;
    recv_stall_max = 3;
    send_item(FUNC_CHAR, CHAR_FIRST, 32'hFFFF_FFFF);
    send_item(FUNC_CHAR, CHAR_LAST, 32'h0);
    send_item(FUNC_CHAR, 8'h41, 32'h1234_5678);
    send_item(FUNC_CHAR, 8'h30, 32'h0);
    send_item(FUNC_CHAR, 8'h7E, 32'hA5A5_A5A5);
    send_item(FUNC_CHAR, 8'h55, 32'h0);
    hold_until_drained();
  endtask

  task automatic test_unprintable_codes();
    send_gap_max   = 0;
    recv_stall_max = 0;
    send_item(FUNC_CHAR, 8'h00, 32'h0000_0001);
    send_item(FUNC_CHAR, 8'h1F, 32'h5A5A_5A5A);
    send_item(FUNC_CHAR, 8'h80, 32'h0);
    send_item(FUNC_CHAR, 8'hFF, 32'hFFFF_FFFF);
    send_item(FUNC_CHAR, 8'hAA, 32'h0);
    hold_until_drained();
  endtask

  task automatic test_decimal_numbers();
    send_gap_max   = 6;
    recv_stall_max = 6;
    send_item(FUNC_NUMBER, 8'h41, 32'd0);
    send_item(FUNC_NUMBER, 8'hFF, 32'd9);
    send_item(FUNC_NUMBER, 8'h00, 32'd10);
    send_item(FUNC_NUMBER, 8'h7F, 32'hFFFF_FFFF);
    send_item(FUNC_NUMBER, 8'h55, 32'd1000000000);
    send_item(FUNC_NUMBER, 8'hAA, 32'd999999999);
    send_item(FUNC_NUMBER, 8'h20, 32'h8000_0000);
    send_item(FUNC_NUMBER, 8'h80, 32'd1234567890);
    hold_until_drained();
  endtask

  // Random items in stretches of different idling, draining between stretches
  task automatic test_random_stream();
    int unsigned gap_plan   [5] = '{6, 0, 6, 0, 3};
    int unsigned stall_plan [5] = '{6, 0, 0, 6, 3};
    for (int phase = 0; phase < 5; phase++) begin
      send_gap_max   = gap_plan[phase];
      recv_stall_max = stall_plan[phase];
      repeat (50) send_random_item();
      hold_until_drained();
    end
  endtask

  // Accept column words after random stalls and compare with the oldest prediction
  initial begin : column_sink
    int unsigned  stall;
    column_word_t want;
    col_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall > 0) begin
        @(negedge clk);
        col_if.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      col_if.ready = 1'b1;
      do @(posedge clk); while (col_if.valid !== 1'b1);
      if (pending_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected column word: column_byte=%h last=%b",
                   col_if.column_byte, col_if.last);
        end
      end else begin
        want = pending_columns.pop_front();
        if (col_if.column_byte !== want.column_byte || col_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("column word mismatch: expected column_byte=%h last=%b, got %h %b",
                     want.column_byte, want.last, col_if.column_byte, col_if.last);
          end
        end
      end
    end
  end

  // End the run when no word moves on either side for too long
  initial begin : quiet_watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst === 1'b0);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
          (col_if.valid === 1'b1 && col_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    item_if.valid     = 1'b0;
    item_if.func      = FUNC_CHAR;
    item_if.char_code = 8'h00;
    item_if.number    = 32'h0;
    mismatches        = 0;
    send_gap_max      = 0;
    recv_stall_max    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_printable_extremes();
    test_unprintable_codes();
    test_decimal_numbers();
    test_random_stream();

    // Drain, then allow for a late stray word
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_columns.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== text_glyph_column_renderer_core.f =====
rtl/core/tgcr_pkg.sv
rtl/core/tgcr_in_if.sv
rtl/core/tgcr_out_if.sv
rtl/core/tgcr_div10.sv
rtl/core/tgcr_glyph.sv
rtl/core/text_glyph_column_renderer_core.sv
rtl/core/tgcr_checker.sv
dv/tb_text_glyph_column_renderer_core.sv
